/* rtl/p10u_pkg.sv */
// ----------------------------------------------------------------------------
// p10u_pkg
// Shared constants, register indexes and types of the packed 10-bit
// window unpacker.
// ----------------------------------------------------------------------------
package p10u_pkg;

	localparam int LINES_PER_SEGMENT = 464;
	localparam int MAX_COLUMNS       = 3712;

	localparam int LANES   = 4;
	localparam int LANE_W  = $clog2(LANES);
	localparam int PIX_W   = 10;
	localparam int POS_W   = 12;
	localparam int LINE_W  = 9;
	localparam int SEG_W   = 3;
	localparam int CHAN_W  = 4;
	localparam int ADDR_W  = 24;
	localparam int GROUP_W = LANES * PIX_W;
	localparam int OUT_W   = 40;

	// highest channel with an output plane
	localparam logic [CHAN_W-1:0] CHAN_MAX = 4'd11;

	// configuration register indexes
	localparam logic [2:0] REG_SEGMENT_INDEX = 3'd0;
	localparam logic [2:0] REG_FIRST_LINE    = 3'd1;
	localparam logic [2:0] REG_FIRST_COLUMN  = 3'd2;
	localparam logic [2:0] REG_WIN_LINES     = 3'd3;
	localparam logic [2:0] REG_WIN_COLUMNS   = 3'd4;
	localparam logic [2:0] REG_LINE_WIDTH    = 3'd5;
	localparam logic [2:0] REG_CHANNEL       = 3'd6;

	// what one lane finds for its pixel
	typedef struct packed {
		logic             hit;
		logic [POS_W-1:0] offset;
	} lane_res_t;

	// one group handed to the merge stage
	typedef struct packed {
		logic [LANES-1:0]             mask;
		logic [LANES-1:0][PIX_W-1:0]  pix;
		logic [LANES-1:0][POS_W-1:0]  off;
		logic [ADDR_W-1:0]            row_base;
		logic [CHAN_W-1:0]            plane;
	} grp_t;

endpackage

/* rtl/p10u_lane.sv */
// ----------------------------------------------------------------------------
// p10u_lane
// Column check for one pixel of a group: inside the stored line, inside
// the column window, and its column offset within the window.
// ----------------------------------------------------------------------------
module p10u_lane
	import p10u_pkg::*;
(
	input  logic [POS_W-1:0]  pos,
	input  logic [LANE_W-1:0] lane_idx,
	input  logic [POS_W-1:0]  line_width,
	input  logic [POS_W-1:0]  col_lo,
	input  logic [POS_W-1:0]  win_cols,
	output lane_res_t         res
);

	logic [POS_W-1:0] col;
	logic [POS_W-1:0] off;

	// column of this pixel; pos is a multiple of four, so no carry out
	assign col = pos + POS_W'(lane_idx);
	assign off = col - col_lo;

	always_comb begin
		res.offset = off;
		res.hit    = (col < line_width) && (col >= col_lo) && (off < win_cols);
	end

endmodule

/* rtl/p10u_merge.sv */
// ----------------------------------------------------------------------------
// p10u_merge
// Merge stage: holds the hits of one group and sends them out one item
// per cycle while m_tready is high, lowest lane first, with tlast on the final hit.
// ----------------------------------------------------------------------------
module p10u_merge
	import p10u_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  grp_t             in_grp,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata,
	output logic             m_tlast
);

	logic [LANES-1:0]             mask_q;
	logic [LANES-1:0][PIX_W-1:0]  pix_q;
	logic [LANES-1:0][ADDR_W-1:0] addr_q;
	logic [CHAN_W-1:0]            plane_q;

	logic [LANE_W-1:0] sel;
	logic [LANES-1:0]  rest;
	logic              fire;
	logic              load;

	// lowest pending lane
	always_comb begin
		sel = '0;
		for (int i = LANES - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				sel = LANE_W'(i);
			end
		end
	end

	always_comb begin
		rest      = mask_q;
		rest[sel] = 1'b0;
	end

	assign m_tvalid = |mask_q;
	assign m_tlast  = (rest == '0);
	assign fire     = m_tvalid && m_tready;
	assign in_ready = !m_tvalid || (fire && m_tlast);
	assign load     = in_valid && in_ready;

	// plane_index, pixel_address, pixel_value from the top down
	assign m_tdata = {{(OUT_W - CHAN_W - ADDR_W - PIX_W){1'b0}},
		plane_q, addr_q[sel], pix_q[sel]};

	// pending mask
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (load) begin
			mask_q <= in_grp.mask;
		end else if (fire) begin
			mask_q <= rest;
		end
	end

	// group payload, addresses formed on load
	always_ff @(posedge clk) begin
		if (load) begin
			pix_q   <= in_grp.pix;
			plane_q <= in_grp.plane;
			for (int i = 0; i < LANES; i++) begin
				addr_q[i] <= in_grp.row_base + ADDR_W'(in_grp.off[i]);
			end
		end
	end

	a_group_continues: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !m_tlast |=> m_tvalid)
		else $error("group dropped before its last item");

	a_group_ends: assert property (@(posedge clk) disable iff (!arst_n)
		fire && m_tlast && !load |=> !m_tvalid)
		else $error("item sent after the last of a group");

endmodule

/* rtl/packed_10bit_window_unpacker_unit.sv */
// ----------------------------------------------------------------------------
// packed_10bit_window_unpacker_unit
// Unpacks four 10-bit pixels per 5-byte group, tracks column and line in
// the segment and emits the pixels inside the window with plane addresses.
//
//   channel  dir  width  handshake            content
//   s_*      in   40     s_tvalid / s_tready  packed_group
//   m_*      out  40+1   m_tvalid / m_tready  pixel, address, plane, tlast
//   cfg_*    in   3+12   cfg_we               register index and data
//
// A group enters in a single transfer; results leave one item per cycle while
// m_tready is high. Between input and first result a group is registered in
// stage 1 (column lanes), stage 2 (row multiply) and the merge buffer.
// Reset clears the position state and loads the register defaults.
// A stalled output fills the merge buffer and then the two pipeline stages
// before s_tready drops; groups with no hits are dropped at stage 2 without
// waiting on the output.
// ----------------------------------------------------------------------------
module packed_10bit_window_unpacker_unit
	import p10u_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	// packed_group
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [GROUP_W-1:0]  s_tdata,
	// pixel_value, pixel_address, plane_index, zero pad
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [OUT_W-1:0]    m_tdata,
	output logic                m_tlast,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [POS_W-1:0]    cfg_data
);

	// configuration registers
	logic [SEG_W-1:0]  seg_q;
	logic [POS_W-1:0]  line_lo_q;
	logic [POS_W-1:0]  col_lo_q;
	logic [POS_W-1:0]  win_lines_q;
	logic [POS_W-1:0]  win_cols_q;
	logic [POS_W-1:0]  line_width_q;
	logic [CHAN_W-1:0] chan_q;

	// position state
	logic [POS_W-1:0]  col_pos_q;
	logic [LINE_W-1:0] line_q;

	// stage 1
	logic                        s1_v_q;
	logic [LANES-1:0][PIX_W-1:0] pix_s1;
	logic [LANES-1:0]            mask_s1;
	logic [LANES-1:0][POS_W-1:0] off_s1;
	logic [POS_W-1:0]            diff_s1;
	logic [CHAN_W-1:0]           plane_s1;

	// stage 2
	logic                        s2_v_q;
	logic [LANES-1:0][PIX_W-1:0] pix_s2;
	logic [LANES-1:0]            mask_s2;
	logic [LANES-1:0][POS_W-1:0] off_s2;
	logic [ADDR_W-1:0]           rowb_s2;
	logic [CHAN_W-1:0]           plane_s2;

	logic              accept;
	logic              s1_move;
	logic              s2_free;
	logic              mrg_ready;
	logic              in_seg;
	logic              chan_ok;
	logic              line_ok;
	logic [POS_W-1:0]  line_abs;
	logic [POS_W-1:0]  line_diff;
	logic [POS_W:0]    col_next;
	lane_res_t         lane_res [LANES];
	logic [LANES-1:0]  hits;
	grp_t              grp;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q        <= '0;
			line_lo_q    <= '0;
			col_lo_q     <= '0;
			win_lines_q  <= POS_W'(MAX_COLUMNS);
			win_cols_q   <= POS_W'(MAX_COLUMNS);
			line_width_q <= POS_W'(MAX_COLUMNS);
			chan_q       <= CHAN_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SEGMENT_INDEX: seg_q        <= cfg_data[SEG_W-1:0];
				REG_FIRST_LINE:    line_lo_q    <= cfg_data;
				REG_FIRST_COLUMN:  col_lo_q     <= cfg_data;
				REG_WIN_LINES:     win_lines_q  <= cfg_data;
				REG_WIN_COLUMNS:   win_cols_q   <= cfg_data;
				REG_LINE_WIDTH:    line_width_q <= cfg_data;
				REG_CHANNEL:       chan_q       <= cfg_data[CHAN_W-1:0];
				default: ;
			endcase
		end
	end

	// flow control
	assign s2_free  = !s2_v_q || (mask_s2 == '0) || mrg_ready;
	assign s1_move  = s1_v_q && s2_free;
	assign s_tready = !s1_v_q || s2_free;
	assign accept   = s_tvalid && s_tready;

	// line checks for the incoming group
	assign in_seg    = line_q < LINE_W'(LINES_PER_SEGMENT);
	assign chan_ok   = (chan_q != '0) && (chan_q <= CHAN_MAX);
	assign line_abs  = POS_W'(seg_q) * POS_W'(LINES_PER_SEGMENT) + POS_W'(line_q);
	assign line_diff = line_abs - line_lo_q;
	assign line_ok   = (line_abs >= line_lo_q) && (line_diff < win_lines_q);
	assign col_next  = {1'b0, col_pos_q} + (POS_W + 1)'(LANES);

	// column lanes
	for (genvar g = 0; g < LANES; g++) begin : g_lane
		p10u_lane u_lane (
			.pos        (col_pos_q),
			.lane_idx   (LANE_W'(g)),
			.line_width (line_width_q),
			.col_lo     (col_lo_q),
			.win_cols   (win_cols_q),
			.res        (lane_res[g])
		);
		assign hits[g] = lane_res[g].hit && in_seg && chan_ok && line_ok;
	end

	// position within the segment
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_pos_q <= '0;
			line_q    <= '0;
		end else if (accept && in_seg) begin
			if (col_next >= {1'b0, line_width_q}) begin
				col_pos_q <= '0;
				line_q    <= line_q + LINE_W'(1);
			end else begin
				col_pos_q <= col_next[POS_W-1:0];
			end
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
			s2_v_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_v_q <= 1'b1;
			end else if (s1_move) begin
				s1_v_q <= 1'b0;
			end
			if (s1_move) begin
				s2_v_q <= 1'b1;
			end else if (s2_free) begin
				s2_v_q <= 1'b0;
			end
		end
	end

	// stage 1: unpacked pixels and lane results, first pixel in the top bits
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < LANES; i++) begin
				pix_s1[i] <= s_tdata[GROUP_W - 1 - i * PIX_W -: PIX_W];
				off_s1[i] <= lane_res[i].offset;
			end
			mask_s1  <= hits;
			diff_s1  <= line_diff;
			plane_s1 <= chan_q - CHAN_W'(1);
		end
	end

	// stage 2: row base of the window plane
	always_ff @(posedge clk) begin
		if (s1_move) begin
			pix_s2   <= pix_s1;
			mask_s2  <= mask_s1;
			off_s2   <= off_s1;
			rowb_s2  <= ADDR_W'(diff_s1 * win_cols_q);
			plane_s2 <= plane_s1;
		end
	end

	always_comb begin
		grp.mask     = mask_s2;
		grp.pix      = pix_s2;
		grp.off      = off_s2;
		grp.row_base = rowb_s2;
		grp.plane    = plane_s2;
	end

	p10u_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s2_v_q && (mask_s2 != '0)),
		.in_ready (mrg_ready),
		.in_grp   (grp),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	a_col_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		col_pos_q[LANE_W-1:0] == '0)
		else $error("column position off group boundary");

	a_line_bound: assert property (@(posedge clk) disable iff (!arst_n)
		line_q <= LINE_W'(LINES_PER_SEGMENT))
		else $error("line counter past segment end");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_v_q |-> s_tready)
		else $error("input stalled with stage 1 empty");

endmodule

/* test/packed_10bit_window_unpacker_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// packed_10bit_window_unpacker_unit_tb
// Self-checking bench for the packed 10-bit window unpacker. A queue-fed
// driver offers 5-byte groups and a monitor checks every pixel item against
// a local model of the unpacker, which tracks column, line and window.
// Directed cases come first, then randomized register phases with random
// groups, a long output hold-off and a final run with no idling.
// ----------------------------------------------------------------------------
module packed_10bit_window_unpacker_unit_tb;
	import p10u_pkg::*;

	// index with no register behind it
	localparam logic [2:0] REG_SPARE = 3'd7;
	localparam int DRAIN_CYCLES = 20;
	localparam int HOLD_CYCLES  = 400;

	typedef struct packed {
		logic [PIX_W-1:0]  value;
		logic [ADDR_W-1:0] addr;
		logic [CHAN_W-1:0] plane;
		logic              last;
	} pixel_t;

	logic clk;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	// packed_group
	logic [GROUP_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	// pixel_value, pixel_address, plane_index, zero pad
	logic [OUT_W-1:0] m_tdata;
	logic m_tlast;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [POS_W-1:0] cfg_data = '0;

	// model registers and position
	int unsigned seg_sel, line_lo, col_lo, win_lines, win_cols, line_w;
	logic [CHAN_W-1:0] chan;
	int unsigned col_pos, seg_line;

	logic [GROUP_W-1:0] group_queue[$];
	pixel_t pixel_expect[$];
	pixel_t head;
	int errors = 0;
	bit idle_en = 1'b1;
	bit hold_trigger = 1'b0;
	bit hold_seen = 1'b0;
	int hold_left = 0;
	int src_gap = 0;
	int sink_gap = 0;

	packed_10bit_window_unpacker_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// unpack one group, queue the pixels inside the window, advance position
	function automatic void predict_group(input logic [GROUP_W-1:0] grp);
		int unsigned line, col, row_base;
		pixel_t hits[$];
		pixel_t p;
		if (seg_line >= LINES_PER_SEGMENT)
			return;
		line = seg_sel * LINES_PER_SEGMENT + seg_line;
		if (line >= line_lo && line - line_lo < win_lines && chan >= 1 &&
				chan <= CHAN_MAX) begin
			row_base = (line - line_lo) * win_cols;
			for (int k = 0; k < LANES; k++) begin
				col = col_pos + k;
				if (col >= line_w)
					continue;
				if (col < col_lo || col - col_lo >= win_cols)
					continue;
				p.value = grp[GROUP_W-1-PIX_W*k -: PIX_W];
				p.addr  = ADDR_W'(row_base + (col - col_lo));
				p.plane = chan - CHAN_W'(1);
				p.last  = 1'b0;
				hits.push_back(p);
			end
			if (hits.size() > 0)
				hits[hits.size()-1].last = 1'b1;
			foreach (hits[i])
				pixel_expect.push_back(hits[i]);
		end
		col_pos += LANES;
		if (col_pos >= line_w) begin
			col_pos = 0;
			seg_line++;
		end
	endfunction

	// driver: offer queued groups, with random gaps
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				predict_group(s_tdata);
			if (!s_tvalid || s_tready) begin
				if (src_gap > 0) begin
					src_gap <= src_gap - 1;
					s_tvalid <= 1'b0;
				end else if (group_queue.size() > 0) begin
					s_tdata <= group_queue.pop_front();
					s_tvalid <= 1'b1;
					if (idle_en && $urandom_range(0, 7) == 0)
						src_gap <= $urandom_range(1, 16);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor: ready pattern and field-by-field check
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (pixel_expect.size() == 0) begin
					$error("pixel item with nothing expected: tdata=%h tlast=%b",
						m_tdata, m_tlast);
					errors++;
				end else begin
					head = pixel_expect.pop_front();
					if (m_tdata[PIX_W-1:0] !== head.value) begin
						$error("pixel_value expected %0d got %0d", head.value,
							m_tdata[PIX_W-1:0]);
						errors++;
					end
					if (m_tdata[PIX_W +: ADDR_W] !== head.addr) begin
						$error("pixel_address expected %0d got %0d", head.addr,
							m_tdata[PIX_W +: ADDR_W]);
						errors++;
					end
					if (m_tdata[PIX_W+ADDR_W +: CHAN_W] !== head.plane) begin
						$error("plane_index expected %0d got %0d", head.plane,
							m_tdata[PIX_W+ADDR_W +: CHAN_W]);
						errors++;
					end
					if (m_tlast !== head.last) begin
						$error("last_of_group expected %0d got %0d", head.last, m_tlast);
						errors++;
					end
				end
			end
			if (hold_trigger != hold_seen) begin
				hold_seen <= hold_trigger;
				hold_left <= HOLD_CYCLES;
				m_tready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				m_tready <= 1'b0;
			end else if (sink_gap > 0) begin
				sink_gap <= sink_gap - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (idle_en && $urandom_range(0, 9) == 0)
					sink_gap <= $urandom_range(1, 16);
			end
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [POS_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_SEGMENT_INDEX: seg_sel    = val[SEG_W-1:0];
			REG_FIRST_LINE:    line_lo    = val;
			REG_FIRST_COLUMN:  col_lo     = val;
			REG_WIN_LINES:     win_lines  = val;
			REG_WIN_COLUMNS:   win_cols   = val;
			REG_LINE_WIDTH:    line_w     = val;
			REG_CHANNEL:       chan       = val[CHAN_W-1:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_group(input logic [GROUP_W-1:0] grp);
		@(negedge clk);
		group_queue.push_back(grp);
	endtask

	// wait for the sender to empty and every pixel to arrive, then let the
	// pipeline settle for groups that hit nothing
	task automatic wait_idle();
		@(negedge clk);
		while (group_queue.size() != 0 || s_tvalid || pixel_expect.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	function automatic logic [GROUP_W-1:0] rand_group();
		logic [7:0] hi;
		logic [31:0] lo;
		hi = 8'($urandom_range(0, 255));
		lo = $urandom;
		case ($urandom_range(0, 15))
			0:       return '0;
			1:       return '1;
			default: return {hi, lo};
		endcase
	endfunction

	function automatic int unsigned pick_extent();
		case ($urandom_range(0, 9))
			0:       return 0;
			1:       return MAX_COLUMNS;
			2:       return 4095;
			3:       return $urandom_range(0, 4095);
			default: return $urandom_range(1, 24);
		endcase
	endfunction

	// one randomized register setting followed by a burst of groups
	task automatic random_phase(input int n_items, input bit full_window);
		int unsigned seg, lw, fl, fc, wl, wc, cur_line, back;
		logic [CHAN_W-1:0] ch;
		logic [7:0] hi8;
		logic [8:0] hi9;
		seg = $urandom_range(0, 7);
		case ($urandom_range(0, 3))
			0:       lw = LANES * $urandom_range(1, 5);
			1:       lw = $urandom_range(1, 24);
			2:       lw = MAX_COLUMNS;
			default: lw = $urandom_range(4, 4095);
		endcase
		cur_line = seg * LINES_PER_SEGMENT + seg_line;
		if ($urandom_range(0, 3) != 0) begin
			back = $urandom_range(0, 6);
			if (back > cur_line)
				back = cur_line;
			fl = cur_line - back;
		end else begin
			fl = $urandom_range(0, 4095);
		end
		wl = pick_extent();
		if ($urandom_range(0, 4) == 0)
			fc = $urandom_range(0, 4095);
		else if (lw <= 24)
			fc = $urandom_range(0, lw - 1);
		else
			fc = $urandom_range(0, 8);
		wc = pick_extent();
		if ($urandom_range(0, 5) == 0)
			ch = CHAN_W'($urandom_range(0, 15));
		else
			ch = CHAN_W'($urandom_range(1, 11));
		if (full_window) begin
			fl = 0;
			fc = 0;
			wl = MAX_COLUMNS;
			wc = MAX_COLUMNS;
			ch = CHAN_MAX;
			lw = LANES * $urandom_range(2, 6);
		end
		hi8 = 8'($urandom_range(0, 255));
		hi9 = 9'($urandom_range(0, 511));
		write_reg(REG_SEGMENT_INDEX, {hi9, seg[SEG_W-1:0]});
		write_reg(REG_FIRST_LINE, POS_W'(fl));
		write_reg(REG_FIRST_COLUMN, POS_W'(fc));
		write_reg(REG_WIN_LINES, POS_W'(wl));
		write_reg(REG_WIN_COLUMNS, POS_W'(wc));
		write_reg(REG_LINE_WIDTH, POS_W'(lw));
		write_reg(REG_CHANNEL, {hi8, ch});
		if ($urandom_range(0, 3) == 0)
			write_reg(REG_SPARE, POS_W'($urandom_range(0, 4095)));
		@(negedge clk);
		idle_en = ($urandom_range(0, 3) != 0);
		for (int i = 0; i < n_items; i++)
			group_queue.push_back(rand_group());
		if (full_window)
			hold_trigger = ~hold_trigger;
		wait_idle();
	endtask

	// time limit
	initial begin
		#10_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		int unsigned final_groups;
		seg_sel    = 0;
		line_lo    = 0;
		col_lo     = 0;
		win_lines  = MAX_COLUMNS;
		win_cols   = MAX_COLUMNS;
		line_w     = MAX_COLUMNS;
		chan       = 1;
		col_pos    = 0;
		seg_line   = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset defaults: full window, extreme and striped pixel patterns
		send_group('0);
		send_group('1);
		send_group(40'hAA_AAAA_AAAA);
		send_group(40'h55_5555_5555);
		send_group({10'h3FF, 10'h000, 10'h3FF, 10'h000});
		send_group({10'h000, 10'h3FF, 10'h000, 10'h3FF});
		send_group({10'h001, 10'h200, 10'h155, 10'h2AA});
		send_group(rand_group());
		wait_idle();

		// line width not a multiple of four; current column lies past it
		write_reg(REG_LINE_WIDTH, 12'd6);
		repeat (4) send_group(rand_group());
		wait_idle();

		// line width below four
		write_reg(REG_LINE_WIDTH, 12'd2);
		repeat (2) send_group(rand_group());
		wait_idle();

		// channels without a plane still advance the position
		write_reg(REG_LINE_WIDTH, 12'd8);
		write_reg(REG_CHANNEL, 12'd0);
		send_group(rand_group());
		wait_idle();
		write_reg(REG_CHANNEL, 12'd12);
		send_group(rand_group());
		wait_idle();
		write_reg(REG_CHANNEL, 12'd15);
		send_group(rand_group());
		wait_idle();

		// empty windows
		write_reg(REG_CHANNEL, POS_W'(CHAN_MAX));
		write_reg(REG_WIN_LINES, 12'd0);
		send_group(rand_group());
		wait_idle();
		write_reg(REG_WIN_LINES, POS_W'(MAX_COLUMNS));
		write_reg(REG_WIN_COLUMNS, 12'd0);
		send_group(rand_group());
		wait_idle();

		// narrow column window, then a write to the spare index
		write_reg(REG_LINE_WIDTH, 12'd16);
		write_reg(REG_FIRST_COLUMN, 12'd2);
		write_reg(REG_WIN_COLUMNS, 12'd3);
		repeat (3) send_group(rand_group());
		wait_idle();
		write_reg(REG_SPARE, 12'hFFF);
		send_group(rand_group());
		wait_idle();

		// window corner at the top extremes selects nothing here
		write_reg(REG_FIRST_LINE, POS_W'(MAX_COLUMNS - 1));
		write_reg(REG_FIRST_COLUMN, POS_W'(MAX_COLUMNS - 1));
		write_reg(REG_WIN_LINES, 12'd1);
		write_reg(REG_WIN_COLUMNS, 12'd1);
		send_group(rand_group());
		wait_idle();

		// random phases; the second stalls the output for a long stretch
		random_phase(15, 1'b0);
		random_phase(24, 1'b1);
		for (int ph = 0; ph < 4; ph++)
			random_phase(12, 1'b0);

		// last segment, full window, one group per line, no idling
		@(negedge clk);
		idle_en = 1'b0;
		write_reg(REG_SEGMENT_INDEX, 12'd7);
		write_reg(REG_FIRST_LINE, 12'd0);
		write_reg(REG_FIRST_COLUMN, 12'd0);
		write_reg(REG_WIN_LINES, POS_W'(MAX_COLUMNS));
		write_reg(REG_WIN_COLUMNS, POS_W'(MAX_COLUMNS));
		write_reg(REG_LINE_WIDTH, POS_W'(LANES));
		write_reg(REG_CHANNEL, POS_W'(CHAN_MAX));
		final_groups = 12;
		for (int i = 0; i < final_groups; i++)
			send_group(rand_group());
		wait_idle();

		if (pixel_expect.size() != 0)
			$error("%0d pixel items never arrived", pixel_expect.size());
		if (errors == 0 && pixel_expect.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

/* packed_10bit_window_unpacker_unit.f */
rtl/p10u_pkg.sv
rtl/p10u_lane.sv
rtl/p10u_merge.sv
rtl/packed_10bit_window_unpacker_unit.sv
test/packed_10bit_window_unpacker_unit_tb.sv
